// ===== rtl/sgd_pkg.sv =====
package sgd_pkg;

  // window and field sizes
  localparam int WINDOW_DEPTH = 50;
  localparam int COORD_W      = 11;
  localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int WORD_W       = 2 * COORD_W;

  localparam logic [COORD_W-1:0] THRESH_RESET = COORD_W'(300);

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_LEFT  = 2'd1,
    GEST_RIGHT = 2'd2
  } gesture_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  // control from the sequencer to each colour lane
  typedef struct packed {
    logic              load;
    logic              dv;
    logic [ADDR_W-1:0] age;
    logic              commit;
  } lane_ctl_t;

endpackage

// ===== rtl/sgd_in_if.sv =====
interface sgd_in_if import sgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] red_x;
  logic [COORD_W-1:0] green_x;

  modport source (output valid, output red_x, output green_x, input ready);
  modport sink   (input valid, input red_x, input green_x, output ready);
endinterface

// ===== rtl/sgd_out_if.sv =====
interface sgd_out_if import sgd_pkg::*; ();
  logic     valid;
  logic     ready;
  gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

// ===== rtl/sgd_hist_ram.sv =====
module sgd_hist_ram import sgd_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [WINDOW_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sgd_lane.sv =====
module sgd_lane import sgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctl_t          ctl,
  input  logic [COORD_W-1:0] sample,
  input  logic [COORD_W-1:0] rd_value,
  input  logic [COORD_W-1:0] thr,
  output gesture_t           result
);

  logic [CNT_W-1:0]   count;
  logic [COORD_W-1:0] newest;
  logic [COORD_W-1:0] prev1;
  logic [COORD_W-1:0] prev2;
  logic               matched;
  gesture_t           dir;

  logic [COORD_W-1:0] value;
  logic [COORD_W:0]   limit;
  logic               hit;

  // ages past the fill count read as cleared
  assign value = (CNT_W'(ctl.age) < count) ? rd_value : '0;
  assign limit = {1'b0, newest} + {1'b0, thr};
  assign hit   = ctl.dv && !matched && (ctl.age >= ADDR_W'(2))
              && ({1'b0, value} > limit) && (value != prev2);

  // fill count: grows on push, drops to zero when the window is cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      matched <= 1'b0;
    end else if (ctl.load) begin
      count   <= (count < CNT_W'(WINDOW_DEPTH)) ? count + CNT_W'(1) : count;
      matched <= 1'b0;
    end else if (ctl.commit) begin
      if (matched) begin
        count <= '0;
      end
    end else if (hit) begin
      matched <= 1'b1;
    end
  end

  // newest sample and the two most recent ages seen by the scan
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      newest <= sample;
      prev1  <= sample;
    end else if (ctl.dv) begin
      prev2 <= prev1;
      prev1 <= value;
    end
    if (hit) begin
      dir <= (value < prev2) ? GEST_LEFT : GEST_RIGHT;
    end
  end

  assign result = matched ? dir : GEST_NONE;

endmodule

// ===== rtl/scroll_gesture_detector.sv =====
// scroll gesture detector
// in_ch carries one beat per frame: red_x and green_x, the horizontal marker
// positions. out_ch returns exactly one beat per input beat with gesture:
// none, scroll left or scroll right. cfg_we / cfg_wdata write the scroll
// threshold, which should only change while no frame is in flight.
// both colour histories sit in one memory of combined words, a ring indexed
// from the newest slot; a fill count per colour marks which ages are live,
// so clearing a history only resets its count. an item is accepted and
// written in the idle state, the scan state reads ages 1 to WINDOW_DEPTH - 1
// on the single memory read port, the wait state covers the read latency
// and the done state forms the result. in_ch.ready is high only while
// the sequencer is idle. a finished result waits in the output register; if
// the receiver stalls with a result still held, the next result waits in
// the done state until the register frees up, while in_ch stays not ready.
// reset empties both histories and sets the threshold to 300.
module scroll_gesture_detector import sgd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sgd_in_if.sink             in_ch,
  sgd_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata
);

  state_t             state, state_next;
  logic [ADDR_W-1:0]  head, head_next;
  logic [ADDR_W-1:0]  issue_age, issue_age_next;
  logic [ADDR_W-1:0]  data_age;
  logic               dv;
  logic [COORD_W-1:0] thr;
  logic               out_valid;
  gesture_t           gesture;

  logic               accept;
  logic               rd_en;
  logic               commit;
  logic [ADDR_W:0]    rd_sum;
  logic [ADDR_W-1:0]  rd_addr;
  logic [WORD_W-1:0]  rd_data;
  lane_ctl_t          ctl;
  gesture_t           red_res, green_res;

  assign accept = in_ch.valid && in_ch.ready;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // ring address of the requested age
  assign rd_sum  = (head >= issue_age) ? ({1'b0, head} - {1'b0, issue_age})
                 : ({1'b0, head} + (ADDR_W+1)'(WINDOW_DEPTH) - {1'b0, issue_age});
  assign rd_addr = rd_sum[ADDR_W-1:0];

  // sequencer next state and controls
  always_comb begin
    state_next     = state;
    issue_age_next = issue_age;
    head_next      = head;
    in_ch.ready    = 1'b0;
    rd_en          = 1'b0;
    commit         = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          head_next      = (head == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : head + ADDR_W'(1);
          issue_age_next = ADDR_W'(1);
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en          = 1'b1;
        issue_age_next = issue_age + ADDR_W'(1);
        if (issue_age == ADDR_W'(WINDOW_DEPTH - 1)) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      issue_age <= '0;
      dv        <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      issue_age <= issue_age_next;
      dv        <= rd_en;
    end
  end

  // age of the word coming out of the memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_age <= issue_age;
    end
  end

  sgd_hist_ram u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (head_next),
    .wdata ({in_ch.red_x, in_ch.green_x}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ctl.load   = accept;
  assign ctl.dv     = dv;
  assign ctl.age    = data_age;
  assign ctl.commit = commit;

  sgd_lane u_red (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sample   (in_ch.red_x),
    .rd_value (rd_data[WORD_W-1:COORD_W]),
    .thr      (thr),
    .result   (red_res)
  );

  sgd_lane u_green (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sample   (in_ch.green_x),
    .rd_value (rd_data[COORD_W-1:0]),
    .thr      (thr),
    .result   (green_res)
  );

  // output register: result beat holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      gesture <= (red_res == green_res) ? red_res : GEST_NONE;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.gesture = gesture;

  // checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted beat did not start a scan");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    dv |-> (state == ST_SCAN || state == ST_WAIT))
    else $error("memory data returned outside the scan");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !out_ch.ready |=> state == ST_DONE)
    else $error("result overwrote a pending output beat");

  a_out_stable_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(gesture))
    else $error("pending gesture beat changed while stalled");

endmodule

// ===== tb/gesture_scoreboard_pkg.sv =====
package gesture_scoreboard_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import sgd_pkg::*;

  // predicts one gesture per frame and checks the results in order
  class gesture_scoreboard;
    logic [COORD_W-1:0] thresh;
    logic [COORD_W-1:0] hist [2][WINDOW_DEPTH];
    gesture_t           expected_q[$];
    int unsigned        n_frames;
    int unsigned        n_results;
    int unsigned        n_errors;
    int unsigned        n_kind [3];

    function new();
      thresh = THRESH_RESET;
      foreach (hist[c, i]) hist[c][i] = '0;
      foreach (n_kind[k]) n_kind[k] = 0;
      n_frames  = 0;
      n_results = 0;
      n_errors  = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // scan one colour's window from age 2 up, clear it on a hit
    function gesture_t scan_colour(int c);
      int       newest;
      int       older;
      int       mid;
      gesture_t g;
      g = GEST_NONE;
      newest = int'(hist[c][0]);
      for (int i = 2; i < WINDOW_DEPTH; i++) begin
        older = int'(hist[c][i]);
        mid   = int'(hist[c][i-2]);
        if ((older - newest) > int'(thresh) && older != mid) begin
          g = (older < mid) ? GEST_LEFT : GEST_RIGHT;
          break;
        end
      end
      if (g != GEST_NONE) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) hist[c][i] = '0;
      end
      return g;
    endfunction

    // accepted input beat: shift both windows and queue the gesture
    function void note_frame(logic [COORD_W-1:0] red, logic [COORD_W-1:0] green);
      gesture_t gr;
      gesture_t gg;
      gesture_t res;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
        hist[0][i] = hist[0][i-1];
        hist[1][i] = hist[1][i-1];
      end
      hist[0][0] = red;
      hist[1][0] = green;
      gr  = scan_colour(0);
      gg  = scan_colour(1);
      res = (gr == gg) ? gr : GEST_NONE;
      expected_q.push_back(res);
      n_kind[int'(res)]++;
      n_frames++;
    endfunction

    // accepted output beat: compare with the oldest expectation
    function void check_gesture(logic [1:0] actual);
      gesture_t exp_g;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected gesture beat, expected none pending, actual %0d",
                 $time, actual);
        n_errors++;
        return;
      end
      exp_g = expected_q.pop_front();
      if (actual !== exp_g) begin
        $display("%0t: gesture mismatch, expected %0d (%s) actual %0d",
                 $time, exp_g, exp_g.name(), actual);
        n_errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/scroll_gesture_detector_tb.sv =====
module scroll_gesture_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgd_pkg::*;
  import gesture_scoreboard_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int TIMEOUT_NS  = 10_000_000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;

  typedef enum {TX_FREE, TX_BURST, TX_LONG} tx_mode_t;
  typedef enum {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [COORD_W-1:0] cfg_wdata;

  sgd_in_if  in_ch();
  sgd_out_if out_ch();

  gesture_scoreboard sb = new();

  tx_mode_t    tx_mode = TX_FREE;
  rx_mode_t    rx_mode = RX_FREE;
  int          burst_left = 0;
  int          rx_hold = 0;
  int unsigned n_sent = 0;
  int unsigned n_settings = 0;

  scroll_gesture_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_mode == RX_FREE) begin
      out_ch.ready <= 1'b1;
      rx_hold = 0;
    end else if (rx_hold == 0) begin
      out_ch.ready <= ~out_ch.ready;
      rx_hold = (rx_mode == RX_LONG) ? $urandom_range(1, 60) : $urandom_range(0, 4);
    end else begin
      rx_hold--;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_gesture(out_ch.gesture);
    end
  end

  function automatic logic [COORD_W-1:0] clamp(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  // one input beat, with burst gaps in front as the sender mode asks
  task automatic send_frame(input logic [COORD_W-1:0] red, input logic [COORD_W-1:0] green);
    if (burst_left <= 0) begin
      if (tx_mode != TX_FREE) begin
        repeat ($urandom_range(0, (tx_mode == TX_LONG) ? 70 : 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    in_ch.valid   = 1'b1;
    in_ch.red_x   = red;
    in_ch.green_x = green;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_frame(red, green);
    burst_left--;
    n_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // threshold write once all results are back
  task automatic write_threshold(input logic [COORD_W-1:0] value);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.thresh = value;
    n_settings++;
  endtask

  // marker sweep; a broken one turns red back partway through, sometimes with a jump
  task automatic send_sweep(input int len, input bit broken);
    int thr;
    int mag;
    int r;
    int g;
    int dr;
    int dg;
    int turn;
    thr = int'(sb.thresh);
    mag = $urandom_range(thr / 45 + 1, thr / 8 + 3);
    if (mag > 250) mag = 250;
    dr = $urandom_range(0, 1) ? mag : -mag;
    case ($urandom_range(0, 19))
      0, 1, 2: dg = -dr;
      3, 4:    dg = 0;
      default: dg = dr + int'($urandom_range(0, 4)) - 2;
    endcase
    r = (dr < 0) ? $urandom_range(1024, COORD_MAX) : $urandom_range(0, 1023);
    g = (dg < 0) ? $urandom_range(1024, COORD_MAX) : $urandom_range(0, 1023);
    turn = broken ? $urandom_range(1, len - 1) : len;
    for (int k = 0; k < len; k++) begin
      if (k == turn) begin
        dr = -dr;
        if ($urandom_range(0, 1)) r = $urandom_range(0, COORD_MAX);
      end
      send_frame(clamp(r), clamp(g));
      r += dr + int'($urandom_range(0, 2)) - 1;
      g += dg + int'($urandom_range(0, 2)) - 1;
    end
  endtask

  // random phase at one threshold and one idling style
  task automatic run_phase(input logic [COORD_W-1:0] thr, input int n,
                           input tx_mode_t tm, input rx_mode_t rm);
    int unsigned start;
    int          pick;
    write_threshold(thr);
    tx_mode = tm;
    rx_mode = rm;
    start   = n_sent;
    while (n_sent - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_sweep($urandom_range(4, 60), 1'b0);
      end else if (pick < 9) begin
        send_sweep($urandom_range(4, 60), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_frame(COORD_W'($urandom_range(0, COORD_MAX)),
                     COORD_W'($urandom_range(0, COORD_MAX)));
        end
      end
    end
  endtask

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d gestures outstanding", $time, sb.pending());
    $display("tb: failure");
    $finish;
  end

  // main sequence
  initial begin
    int guard;
    in_ch.valid   = 1'b0;
    in_ch.red_x   = '0;
    in_ch.green_x = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extreme positions, both colours scrolling right
    write_threshold(THRESH_RESET);
    send_frame(11'd0, 11'd0);
    send_frame(11'd2047, 11'd2047);
    send_frame(11'd0, 11'd0);
    send_frame(11'd0, 11'd0);
    // both colours scrolling left, matched past age 2
    send_frame(11'd500, 11'd500);
    send_frame(11'd300, 11'd300);
    send_frame(11'd800, 11'd800);
    send_frame(11'd100, 11'd100);
    // colours disagree: red left, green right
    send_frame(11'd500, 11'd1000);
    send_frame(11'd300, 11'd1000);
    send_frame(11'd800, 11'd1000);
    send_frame(11'd100, 11'd100);
    // red matches alone, green stays still
    send_frame(11'd500, 11'd700);
    send_frame(11'd300, 11'd700);
    send_frame(11'd800, 11'd700);
    send_frame(11'd100, 11'd700);
    // zero threshold, then an older sample equal to the one two ages newer
    write_threshold('0);
    send_frame(11'd10, 11'd10);
    send_frame(11'd5, 11'd5);
    send_frame(11'd5, 11'd5);
    send_frame(11'd7, 11'd7);
    send_frame(11'd3, 11'd3);
    send_frame(11'd7, 11'd7);
    send_frame(11'd3, 11'd3);
    // top threshold can never be exceeded
    write_threshold(11'd2047);
    send_frame(11'd2047, 11'd2047);
    send_frame(11'd0, 11'd0);
    send_frame(11'd0, 11'd0);

    // random phases
    run_phase('0,                          190, TX_BURST, RX_CHOPPY);
    run_phase(11'd2047,                    190, TX_LONG,  RX_FREE);
    run_phase(11'd1,                       190, TX_FREE,  RX_LONG);
    run_phase(THRESH_RESET,                190, TX_FREE,  RX_FREE);
    run_phase(COORD_W'($urandom_range(0, COORD_MAX)), 190, TX_LONG, RX_CHOPPY);
    run_phase(11'd2046,                    190, TX_BURST, RX_LONG);
    run_phase(11'd40,                      190, TX_LONG,  RX_LONG);
    run_phase(COORD_W'($urandom_range(0, 600)), 190, TX_BURST, RX_FREE);

    // drain
    in_ch.valid = 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (WINDOW_DEPTH + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected gestures never arrived", $time, sb.pending());
      sb.n_errors++;
    end

    $display("frames sent %0d, results checked %0d, threshold settings %0d",
             sb.n_frames, sb.n_results, n_settings);
    $display("expected gestures: none %0d, scroll left %0d, scroll right %0d",
             sb.n_kind[int'(GEST_NONE)], sb.n_kind[int'(GEST_LEFT)],
             sb.n_kind[int'(GEST_RIGHT)]);
    if (sb.n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== scroll_gesture_detector.f =====
rtl/sgd_pkg.sv
rtl/sgd_in_if.sv
rtl/sgd_out_if.sv
rtl/sgd_hist_ram.sv
rtl/sgd_lane.sv
rtl/scroll_gesture_detector.sv
tb/gesture_scoreboard_pkg.sv
tb/scroll_gesture_detector_tb.sv
